### src/alm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types, widths and constants of the audio level meter.
// ----------------------------------------------------------------------------
package alm_pkg;

   localparam int CHANNELS  = 8;
   localparam int CHAN_W    = 3;
   localparam int SAMPLE_W  = 16;
   localparam int MAG_W     = 9;
   localparam int SUM_W     = 16;
   localparam int CNT_W     = 8;
   localparam int RUN_W     = 4;
   localparam int CST_W     = 2;
   localparam int LEVEL_W   = 15;
   localparam int AGE_W     = 6;
   localparam int HOLD_W    = 6;
   localparam int CLIPL_W   = 9;
   localparam int QUO_W     = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;

   // serial divider: dividend and divisor widths, step counter width
   localparam int DIV_W     = 27;
   localparam int DVS_W     = 12;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // clip codes
   localparam logic [CST_W-1:0] CLIP_NONE  = 2'd0;
   localparam logic [CST_W-1:0] CLIP_SHORT = 2'd1;
   localparam logic [CST_W-1:0] CLIP_LONG  = 2'd2;

   localparam logic [RUN_W-1:0] RUN_SHORT = 4'd3;
   localparam logic [RUN_W-1:0] RUN_LONG  = 4'd10;
   localparam logic [RUN_W-1:0] RUN_SAT   = 4'd11;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   // levels in Q1.14
   localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 15'd16384;
   localparam logic [LEVEL_W-1:0] LEVEL_SHORT = 15'd15993;
   localparam logic [LEVEL_W-1:0] LEVEL_ZERO  = 15'd0;

   // level = floor(q * 327680 / 2667); q * 327680 = (q * 5) << 16
   localparam logic [DVS_W-1:0] SCALE_DIVISOR = 12'd2667;
   localparam int               SCALE_SHIFT   = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_SAMPLES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_BLOCKS = 2'd2;

   localparam logic [CNT_W-1:0]   MAX_SAMPLES_RST = 8'd200;
   localparam logic [CLIPL_W-1:0] CLIP_LEVEL_RST  = 9'd128;
   localparam logic [HOLD_W-1:0]  HOLD_BLOCKS_RST = 6'd50;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
      logic [CST_W-1:0] cstate;
   } acc_status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // magnitude of sample/128, truncated toward zero: 0..256
   function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] a;
      a = s[SAMPLE_W-1] ? SAMPLE_W'(~s + 1'b1) : s;
      return a[SAMPLE_W-1:SAMPLE_W-MAG_W];
   endfunction

endpackage

### src/alm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [alm_pkg::DIV_W-1:0]     dividend,
   input  logic [alm_pkg::DVS_W-1:0]     divisor,
   output logic [alm_pkg::DIV_W-1:0]     quotient,
   output alm_pkg::div_status_type       status
);

   logic [alm_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [alm_pkg::DVS_W-1:0]     rem_ff, rem_in;
   logic [alm_pkg::DVS_W-1:0]     dvs_ff;
   logic [alm_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                          busy_ff, done_ff;
   logic [alm_pkg::DVS_W:0]       trial;
   logic [alm_pkg::DVS_W:0]       diff;

   // shift the next dividend bit into the remainder and try the subtract
   assign trial = {rem_ff, quo_ff[alm_pkg::DIV_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      if (!diff[alm_pkg::DVS_W]) begin
         rem_in = diff[alm_pkg::DVS_W-1:0];
         quo_in = {quo_ff[alm_pkg::DIV_W-2:0], 1'b1};
      end else begin
         rem_in = trial[alm_pkg::DVS_W-1:0];
         quo_in = {quo_ff[alm_pkg::DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == alm_pkg::DIV_CNT_W'(alm_pkg::DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### src/alm_acc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_acc
// Per-channel magnitude sum, sample count and clip run tracking.
// ----------------------------------------------------------------------------
module alm_acc (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  logic [alm_pkg::CHAN_W-1:0]      take_ch,
   input  logic [alm_pkg::MAG_W-1:0]       mag,
   input  logic                            clear,
   input  logic [alm_pkg::CHAN_W-1:0]      rd_ch,
   input  logic [alm_pkg::CNT_W-1:0]       max_samples,
   input  logic [alm_pkg::CLIPL_W-1:0]     clip_level,
   output alm_pkg::acc_status_type         status
);

   logic [alm_pkg::SUM_W-1:0] sum_ff  [alm_pkg::CHANNELS];
   logic [alm_pkg::CNT_W-1:0] cnt_ff  [alm_pkg::CHANNELS];
   logic [alm_pkg::RUN_W-1:0] run_ff  [alm_pkg::CHANNELS];
   logic [alm_pkg::CST_W-1:0] cst_ff  [alm_pkg::CHANNELS];

   logic [alm_pkg::SUM_W-1:0] sum_in;
   logic [alm_pkg::CNT_W-1:0] cnt_in;
   logic [alm_pkg::RUN_W-1:0] run_in;
   logic [alm_pkg::CST_W-1:0] cst_in;
   logic                      counts;

   always_comb begin
      counts = (cst_ff[take_ch] != alm_pkg::CLIP_LONG) && (cnt_ff[take_ch] < max_samples);
      sum_in = sum_ff[take_ch] + alm_pkg::SUM_W'(mag);
      cnt_in = cnt_ff[take_ch] + 1'b1;
      if (alm_pkg::CLIPL_W'(mag) == clip_level) begin
         run_in = (run_ff[take_ch] < alm_pkg::RUN_SAT) ? run_ff[take_ch] + 1'b1
                                                       : run_ff[take_ch];
      end else begin
         run_in = '0;
      end
      if (run_in > alm_pkg::RUN_LONG) begin
         cst_in = alm_pkg::CLIP_LONG;
      end else if (run_in > alm_pkg::RUN_SHORT) begin
         cst_in = alm_pkg::CLIP_SHORT;
      end else begin
         cst_in = cst_ff[take_ch];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < alm_pkg::CHANNELS; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
            run_ff[i] <= '0;
            cst_ff[i] <= alm_pkg::CLIP_NONE;
         end
      end else if (clear) begin
         sum_ff[rd_ch] <= '0;
         cnt_ff[rd_ch] <= '0;
         run_ff[rd_ch] <= '0;
         cst_ff[rd_ch] <= alm_pkg::CLIP_NONE;
      end else if (take && counts) begin
         sum_ff[take_ch] <= sum_in;
         cnt_ff[take_ch] <= cnt_in;
         run_ff[take_ch] <= run_in;
         cst_ff[take_ch] <= cst_in;
      end
   end

   assign status.sum    = sum_ff[rd_ch];
   assign status.count  = cnt_ff[rd_ch];
   assign status.cstate = cst_ff[rd_ch];

endmodule

### src/alm_peak.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_peak
// Per-channel held peak and its age in blocks.
// ----------------------------------------------------------------------------
module alm_peak (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          commit,
   input  logic [alm_pkg::CHAN_W-1:0]    ch,
   input  logic [alm_pkg::LEVEL_W-1:0]   level,
   input  logic [alm_pkg::HOLD_W-1:0]    hold_blocks,
   output logic [alm_pkg::LEVEL_W-1:0]   peak_new
);

   logic [alm_pkg::LEVEL_W-1:0] peak_ff [alm_pkg::CHANNELS];
   logic [alm_pkg::AGE_W-1:0]   age_ff  [alm_pkg::CHANNELS];
   logic [alm_pkg::AGE_W-1:0]   age_inc, age_in;
   logic                        replace;

   always_comb begin
      age_inc  = (age_ff[ch] == alm_pkg::AGE_MAX) ? age_ff[ch] : age_ff[ch] + 1'b1;
      replace  = (peak_ff[ch] < level) || (age_inc > alm_pkg::AGE_W'(hold_blocks));
      peak_new = replace ? level : peak_ff[ch];
      age_in   = replace ? '0 : age_inc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < alm_pkg::CHANNELS; i++) begin
            peak_ff[i] <= '0;
            age_ff[i]  <= '0;
         end
      end else if (commit) begin
         peak_ff[ch] <= peak_new;
         age_ff[ch]  <= age_in;
      end
   end

endmodule

### src/audio_level_meter_peak_hold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_level_meter_peak_hold_core
// Per-channel block level meter with peak hold, serial level division.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one sample word per handshake (sample, channel, block_end).
//            A word is taken when req_valid is high and req_stall low.
//   rsp_*  : one level word per block end (channel, level, peak, clip code).
//   csr_*  : register writes (index 0 max_samples, 1 clip_level,
//            2 hold_blocks); csr_ready is always high. Write only while idle.
// Input flow:
//   A word without block_end is summed in the cycle it is taken; the next
//   word is taken in the following cycle. A block_end word holds req_stall
//   high while its level is formed: through two 27-step passes of the
//   bit-serial divider when the level needs the mean, through neither
//   when the block clipped or counted nothing.
// Stall: the result sits in an output register; while rsp_stall holds it,
//   further sample words are still taken, and the next block end waits for
//   the register to free before it commits.
// Reset clears all channel state, the held peaks and loads register defaults.
// ----------------------------------------------------------------------------
module audio_level_meter_peak_hold_core (
   input  logic                              clock,
   input  logic                              reset,
   // sample words
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [alm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [alm_pkg::CHAN_W-1:0]        req_channel,
   input  logic                              req_block_end,
   // level words
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [alm_pkg::CHAN_W-1:0]        rsp_out_channel,
   output logic [alm_pkg::LEVEL_W-1:0]       rsp_level,
   output logic [alm_pkg::LEVEL_W-1:0]       rsp_peak,
   output logic [alm_pkg::CST_W-1:0]         rsp_clip_code,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [alm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [alm_pkg::CSR_DAT_W-1:0]     csr_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_DIV1 = 3'd2;
   localparam logic [2:0] S_DIV2 = 3'd3;
   localparam logic [2:0] S_POST = 3'd4;

   logic [2:0]                    state_ff, state_in;
   logic [alm_pkg::CHAN_W-1:0]    ch_ff;
   logic [alm_pkg::LEVEL_W-1:0]   level_ff, level_in;

   logic [alm_pkg::CNT_W-1:0]     max_samples_ff;
   logic [alm_pkg::CLIPL_W-1:0]   clip_level_ff;
   logic [alm_pkg::HOLD_W-1:0]    hold_blocks_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [alm_pkg::CHAN_W-1:0]    rsp_ch_ff;
   logic [alm_pkg::LEVEL_W-1:0]   rsp_level_ff, rsp_peak_ff;
   logic [alm_pkg::CST_W-1:0]     rsp_clip_ff;

   logic                          accept, chan_ok, take, needs_div, commit;
   logic [alm_pkg::MAG_W-1:0]     mag;
   alm_pkg::acc_status_type       acc_st;
   alm_pkg::div_status_type       div_st;
   logic                          div_start;
   logic [alm_pkg::DIV_W-1:0]     div_dividend, div_quo;
   logic [alm_pkg::DVS_W-1:0]     div_divisor;
   logic [alm_pkg::QUO_W-1:0]     mean;
   logic [alm_pkg::DIV_W-alm_pkg::SCALE_SHIFT-1:0] mean5;
   logic [alm_pkg::LEVEL_W-1:0]   peak_new;

   // ---- input side --------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign chan_ok   = (32'(req_channel) < alm_pkg::CHANNELS);
   assign take      = accept && chan_ok;
   assign mag       = alm_pkg::sample_mag(req_sample);

   // ---- registers ---------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_samples_ff <= alm_pkg::MAX_SAMPLES_RST;
         clip_level_ff  <= alm_pkg::CLIP_LEVEL_RST;
         hold_blocks_ff <= alm_pkg::HOLD_BLOCKS_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            alm_pkg::REG_MAX_SAMPLES: max_samples_ff <= csr_data[alm_pkg::CNT_W-1:0];
            alm_pkg::REG_CLIP_LEVEL:  clip_level_ff  <= csr_data[alm_pkg::CLIPL_W-1:0];
            alm_pkg::REG_HOLD_BLOCKS: hold_blocks_ff <= csr_data[alm_pkg::HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- channel accumulators ---------------------------------------------
   alm_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .take_ch     (req_channel),
      .mag         (mag),
      .clear       (commit),
      .rd_ch       (ch_ff),
      .max_samples (max_samples_ff),
      .clip_level  (clip_level_ff),
      .status      (acc_st)
   );

   // ---- level: mean = sum / count, then level = mean * 327680 / 2667 -------
   assign needs_div = (acc_st.cstate == alm_pkg::CLIP_NONE) && (acc_st.count != '0);
   assign mean      = div_quo[alm_pkg::QUO_W-1:0];
   // mean * 5, widened so the shift by SCALE_SHIFT lands on DIV_W bits
   assign mean5     = {mean, 2'b00} + (alm_pkg::DIV_W-alm_pkg::SCALE_SHIFT)'(mean);

   assign div_start    = ((state_ff == S_EVAL) && needs_div) ||
                         ((state_ff == S_DIV1) && div_st.done);
   assign div_dividend = (state_ff == S_EVAL) ? alm_pkg::DIV_W'(acc_st.sum)
                                              : {mean5, {alm_pkg::SCALE_SHIFT{1'b0}}};
   assign div_divisor  = (state_ff == S_EVAL) ? alm_pkg::DVS_W'(acc_st.count)
                                              : alm_pkg::SCALE_DIVISOR;

   alm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .status   (div_st)
   );

   // ---- peak hold --------------------------------------------------------
   alm_peak u_peak (
      .clock       (clock),
      .reset       (reset),
      .commit      (commit),
      .ch          (ch_ff),
      .level       (level_ff),
      .hold_blocks (hold_blocks_ff),
      .peak_new    (peak_new)
   );

   // ---- sequencer ----------------------------------------------------------
   // commit once the output register is free or being emptied this cycle
   assign commit = (state_ff == S_POST) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      level_in = level_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take && req_block_end) state_in = S_EVAL;
         end
         S_EVAL: begin
            if (needs_div) begin
               state_in = S_DIV1;
            end else begin
               state_in = S_POST;
               case (acc_st.cstate)
                  alm_pkg::CLIP_LONG:  level_in = alm_pkg::LEVEL_FULL;
                  alm_pkg::CLIP_SHORT: level_in = alm_pkg::LEVEL_SHORT;
                  default:             level_in = alm_pkg::LEVEL_ZERO;
               endcase
            end
         end
         S_DIV1: begin
            if (div_st.done) state_in = S_DIV2;
         end
         S_DIV2: begin
            if (div_st.done) begin
               state_in = S_POST;
               level_in = div_quo[alm_pkg::LEVEL_W-1:0];
            end
         end
         S_POST: begin
            if (commit) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      if (accept) ch_ff <= req_channel;
   end

   // ---- output register ----------------------------------------------------
   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ch_ff    <= ch_ff;
         rsp_level_ff <= level_ff;
         rsp_peak_ff  <= peak_new;
         rsp_clip_ff  <= acc_st.cstate;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_peak        = rsp_peak_ff;
   assign rsp_clip_code   = rsp_clip_ff;

   // ---- checks -------------------------------------------------------------
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_POST))
      else $error("level word raised without a commit");

   a_div_not_restarted: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_st.busy)
      else $error("divider started while busy");

   a_div2_after_div1: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV2) && !$past(state_ff == S_DIV2) |-> $past(state_ff == S_DIV1))
      else $error("scaling pass entered without mean pass");

   a_long_clip_full_scale: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POST) && (acc_st.cstate == alm_pkg::CLIP_LONG)
      |-> (level_ff == alm_pkg::LEVEL_FULL))
      else $error("long clip run without a full-scale level");

endmodule

### tb/tb_audio_level_meter_peak_hold_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_level_meter_peak_hold_core
// Self-checking bench for the per-channel block level meter with peak hold.
// A short probe table covers the reset state, full-scale samples and both
// clip codes. Randomised phases follow, each under its own register setting.
// Every level word is checked field by field against a hand-typed word or a
// local model of the meter that the bench keeps itself. Sample words arrive
// in bursts, and the level channel stalls in windows of varying density.
// ----------------------------------------------------------------------------
module tb_audio_level_meter_peak_hold_core;

   // ---- bench constants ----------------------------------------------------
   localparam int     STALL_LIMIT    = 5000;   // cycles with no handshake at all
   localparam int     DRAIN_CYCLES   = 80;     // covers a block end with both divider passes
   localparam int     PHASES         = 8;
   localparam int     PHASE_WORDS    = 245;
   localparam longint LEVEL_MUL      = 40 * 16384;
   localparam longint LEVEL_DIV      = 42 * 127;

   typedef enum int {SRC_WIDE, SRC_CLIPPY, SRC_CLIPPED, SRC_QUIET, SRC_EXTREME}
      sample_src_type;

   typedef struct packed {
      logic [alm_pkg::CHAN_W-1:0]  channel;
      logic [alm_pkg::LEVEL_W-1:0] level;
      logic [alm_pkg::LEVEL_W-1:0] peak;
      logic [alm_pkg::CST_W-1:0]   clip;
   } level_word_type;

   typedef struct packed {
      logic signed [alm_pkg::SAMPLE_W-1:0] sample;
      logic [alm_pkg::CHAN_W-1:0]          channel;
      logic                                block_end;
      logic                                typed;      // expected word given by hand
      level_word_type                      want;
   } probe_row_type;

   // ---- DUT connections ----------------------------------------------------
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic signed [alm_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic [alm_pkg::CHAN_W-1:0]          req_channel = '0;
   logic                                req_block_end = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [alm_pkg::CHAN_W-1:0]          rsp_out_channel;
   logic [alm_pkg::LEVEL_W-1:0]         rsp_level;
   logic [alm_pkg::LEVEL_W-1:0]         rsp_peak;
   logic [alm_pkg::CST_W-1:0]           rsp_clip_code;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [alm_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [alm_pkg::CSR_DAT_W-1:0]       csr_data = '0;

   audio_level_meter_peak_hold_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_channel     (req_channel),
      .req_block_end   (req_block_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_level       (rsp_level),
      .rsp_peak        (rsp_peak),
      .rsp_clip_code   (rsp_clip_code),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ---- meter model state --------------------------------------------------
   logic [alm_pkg::CNT_W-1:0]   cfg_max_samples = alm_pkg::MAX_SAMPLES_RST;
   logic [alm_pkg::CLIPL_W-1:0] cfg_clip_level  = alm_pkg::CLIP_LEVEL_RST;
   logic [alm_pkg::HOLD_W-1:0]  cfg_hold_blocks = alm_pkg::HOLD_BLOCKS_RST;

   logic [alm_pkg::SUM_W-1:0]   mag_total [alm_pkg::CHANNELS];
   logic [alm_pkg::CNT_W-1:0]   mag_count [alm_pkg::CHANNELS];
   logic [alm_pkg::RUN_W-1:0]   clip_len  [alm_pkg::CHANNELS];
   logic [alm_pkg::CST_W-1:0]   clip_mark [alm_pkg::CHANNELS];
   logic [alm_pkg::LEVEL_W-1:0] peak_hold [alm_pkg::CHANNELS];
   logic [alm_pkg::AGE_W-1:0]   hold_age  [alm_pkg::CHANNELS];

   level_word_type expected_levels [$];
   probe_row_type  probe_rows [$];

   // stimulus plan per channel: words left in the block and the sample source
   int             block_left [alm_pkg::CHANNELS];
   sample_src_type block_src  [alm_pkg::CHANNELS];

   int burst_left     = 0;
   int fail_count     = 0;
   int words_sent     = 0;
   int levels_checked = 0;
   int settings_used  = 1;
   int clip_seen [3]  = '{0, 0, 0};
   int stall_pct      = 0;
   int window_left    = 0;
   int idle_cycles;

   // Advance the meter model by one sample word; return 1 with the level word
   // when the word closes its channel's block.
   function automatic bit meter_step(input logic signed [alm_pkg::SAMPLE_W-1:0] s,
                                     input logic [alm_pkg::CHAN_W-1:0] ch, input logic be,
                                     output level_word_type w);
      int                          mag;
      int                          mean;
      longint                      scaled;
      logic [alm_pkg::LEVEL_W-1:0] lvl;
      mag = s;
      if (mag < 0) begin
         mag = -mag;
      end
      mag = mag / 128;
      w = '0;
      // count the sample unless the block hit a long clip or the sample limit
      if (clip_mark[ch] != alm_pkg::CLIP_LONG && mag_count[ch] < cfg_max_samples) begin
         mag_total[ch] = mag_total[ch] + alm_pkg::SUM_W'(mag);
         mag_count[ch] = mag_count[ch] + 1'b1;
         if (mag == int'(cfg_clip_level)) begin
            if (clip_len[ch] < alm_pkg::RUN_SAT) begin
               clip_len[ch] = clip_len[ch] + 1'b1;
            end
         end else begin
            clip_len[ch] = '0;
         end
         if (clip_len[ch] > alm_pkg::RUN_LONG) begin
            clip_mark[ch] = alm_pkg::CLIP_LONG;
         end else if (clip_len[ch] > alm_pkg::RUN_SHORT) begin
            clip_mark[ch] = alm_pkg::CLIP_SHORT;
         end
      end
      if (!be) begin
         return 1'b0;
      end
      if (clip_mark[ch] == alm_pkg::CLIP_LONG) begin
         lvl = alm_pkg::LEVEL_FULL;
      end else if (clip_mark[ch] == alm_pkg::CLIP_SHORT) begin
         lvl = alm_pkg::LEVEL_SHORT;
      end else if (mag_count[ch] == '0) begin
         lvl = alm_pkg::LEVEL_ZERO;
      end else begin
         mean   = int'(mag_total[ch]) / int'(mag_count[ch]);
         scaled = longint'(mean) * LEVEL_MUL / LEVEL_DIV;
         lvl    = alm_pkg::LEVEL_W'(scaled);
      end
      // age the held peak, replace it when beaten or expired
      if (hold_age[ch] != alm_pkg::AGE_MAX) begin
         hold_age[ch] = hold_age[ch] + 1'b1;
      end
      if (peak_hold[ch] < lvl || hold_age[ch] > cfg_hold_blocks) begin
         hold_age[ch]  = '0;
         peak_hold[ch] = lvl;
      end
      w.channel = ch;
      w.level   = lvl;
      w.peak    = peak_hold[ch];
      w.clip    = clip_mark[ch];
      mag_total[ch] = '0;
      mag_count[ch] = '0;
      clip_len[ch]  = '0;
      clip_mark[ch] = alm_pkg::CLIP_NONE;
      return 1'b1;
   endfunction

   // Draw one sample from the given source under the current clip level.
   function automatic logic signed [alm_pkg::SAMPLE_W-1:0] draw_sample(
         input sample_src_type src);
      int v;
      if (src == SRC_CLIPPED || (src == SRC_CLIPPY && $urandom_range(0, 99) < 85)) begin
         if (cfg_clip_level < 256) begin
            v = int'(cfg_clip_level) * 128 + int'($urandom_range(0, 127));
            return alm_pkg::SAMPLE_W'($urandom_range(0, 1) ? -v : v);
         end else if (cfg_clip_level == 256) begin
            return alm_pkg::SAMPLE_W'(-32768);
         end
         return alm_pkg::SAMPLE_W'($urandom);
      end
      case (src)
         SRC_QUIET: begin
            return alm_pkg::SAMPLE_W'(int'($urandom_range(0, 1023)) - 512);
         end
         SRC_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return alm_pkg::SAMPLE_W'(32767);
               1:       return alm_pkg::SAMPLE_W'(-32768);
               2:       return alm_pkg::SAMPLE_W'(-32767);
               3:       return alm_pkg::SAMPLE_W'(-1);
               default: return alm_pkg::SAMPLE_W'(0);
            endcase
         end
         default: begin
            return alm_pkg::SAMPLE_W'($urandom);
         end
      endcase
   endfunction

   // Offer one sample word in bursts with random gaps; hold it until taken,
   // then queue the level word that it closes, if any.
   task automatic send_word(input logic signed [alm_pkg::SAMPLE_W-1:0] s,
                            input logic [alm_pkg::CHAN_W-1:0] ch,
                            input logic be, input logic typed, input level_word_type want);
      level_word_type w;
      int             gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         // one burst in four runs long with no gaps at all
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
      end
      req_valid     <= 1'b1;
      req_sample    <= s;
      req_channel   <= ch;
      req_block_end <= be;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
      words_sent++;
      if (meter_step(s, ch, be, w)) begin
         expected_levels.push_back(typed ? want : w);
      end
   endtask

   task automatic write_reg(input logic [alm_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= alm_pkg::CSR_DAT_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         alm_pkg::REG_MAX_SAMPLES: cfg_max_samples = alm_pkg::CNT_W'(value);
         alm_pkg::REG_CLIP_LEVEL:  cfg_clip_level  = alm_pkg::CLIPL_W'(value);
         alm_pkg::REG_HOLD_BLOCKS: cfg_hold_blocks = alm_pkg::HOLD_W'(value);
         default: ;
      endcase
   endtask

   // Let every outstanding level word arrive, then allow the divider to settle.
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_row(input int s, input int ch, input logic be, input logic typed,
                          input int lvl, input int pk, input logic [alm_pkg::CST_W-1:0] cc);
      probe_row_type r;
      r.sample       = alm_pkg::SAMPLE_W'(s);
      r.channel      = alm_pkg::CHAN_W'(ch);
      r.block_end    = be;
      r.typed        = typed;
      r.want.channel = alm_pkg::CHAN_W'(ch);
      r.want.level   = alm_pkg::LEVEL_W'(lvl);
      r.want.peak    = alm_pkg::LEVEL_W'(pk);
      r.want.clip    = cc;
      probe_rows.push_back(r);
   endtask

   task automatic check_field(input string name, input int want_v, input int got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fail_count++;
      end
   endtask

   // ---- level word checker and stall pattern --------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_levels.size() == 0) begin
            $error("level word on channel %0d with nothing expected", rsp_out_channel);
            fail_count++;
         end else begin
            check_field("out_channel", expected_levels[0].channel, rsp_out_channel);
            check_field("level", expected_levels[0].level, rsp_level);
            check_field("peak", expected_levels[0].peak, rsp_peak);
            check_field("clip_code", expected_levels[0].clip, rsp_clip_code);
            void'(expected_levels.pop_front());
            levels_checked++;
            if (rsp_clip_code <= alm_pkg::CLIP_LONG) begin
               clip_seen[rsp_clip_code]++;
            end
         end
      end
      // stall in windows: some clean, some light, some heavy
      if (window_left == 0) begin
         window_left = $urandom_range(100, 500);
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 60;
            default: stall_pct = 90;
         endcase
      end
      window_left--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // ---- watchdog: end the run if no handshake happens for too long ----------
   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("audio_level_meter_peak_hold_core regression: fail");
      $finish;
   end

   // ---- stimulus ----------------------------------------------------------
   initial begin
      int                           k;
      int                           ph;
      logic [alm_pkg::CHANNELS-1:0] chan_mask;
      bit                           short_blocks;
      logic [alm_pkg::CHAN_W-1:0]   ch;
      logic                         be;
      level_word_type               none;
      none = '0;
      for (k = 0; k < alm_pkg::CHANNELS; k++) begin
         mag_total[k]  = '0;
         mag_count[k]  = '0;
         clip_len[k]   = '0;
         clip_mark[k]  = alm_pkg::CLIP_NONE;
         peak_hold[k]  = '0;
         hold_age[k]   = '0;
         block_left[k] = 0;
         block_src[k]  = SRC_WIDE;
      end

      // Probe table at reset defaults. Silence after reset, full-scale
      // samples of both signs, then a short clip run on channel 3 interleaved
      // with a long clip run on channel 4 that swallows its closing sample.
      add_row(0, 0, 1'b1, 1'b1, 0, 0, alm_pkg::CLIP_NONE);
      add_row(32767, 1, 1'b1, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(-32768, 2, 1'b1, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(16384, 3, 1'b0, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(-16384, 4, 1'b0, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(16511, 3, 1'b0, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(-16511, 4, 1'b0, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(16400, 3, 1'b0, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(16384, 4, 1'b0, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(16384, 3, 1'b1, 1'b1, alm_pkg::LEVEL_SHORT, alm_pkg::LEVEL_SHORT,
              alm_pkg::CLIP_SHORT);
      for (k = 0; k < 8; k++) begin
         add_row(k[0] ? 16500 : -16384, 4, 1'b0, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      end
      add_row(32767, 4, 1'b1, 1'b1, alm_pkg::LEVEL_FULL, alm_pkg::LEVEL_FULL,
              alm_pkg::CLIP_LONG);
      // a silent block keeps the held clip peak
      add_row(0, 3, 1'b1, 1'b1, 0, alm_pkg::LEVEL_SHORT, alm_pkg::CLIP_NONE);
      add_row(-1, 5, 1'b0, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(-129, 5, 1'b1, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(1, 6, 1'b1, 1'b0, 0, 0, alm_pkg::CLIP_NONE);
      add_row(-32767, 7, 1'b1, 1'b0, 0, 0, alm_pkg::CLIP_NONE);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (probe_rows[i]) begin
         send_word(probe_rows[i].sample, probe_rows[i].channel, probe_rows[i].block_end,
                   probe_rows[i].typed, probe_rows[i].want);
      end

      // Random phases. The first three pin the register extremes: longest
      // hold with the top clip level on few channels, a one-sample limit with
      // clip level zero and no hold, then a zero sample limit with a clip
      // level that can never match.
      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         case (ph)
            0: begin
               write_reg(alm_pkg::REG_MAX_SAMPLES, 255);
               write_reg(alm_pkg::REG_CLIP_LEVEL, 256);
               write_reg(alm_pkg::REG_HOLD_BLOCKS, 63);
               chan_mask    = 8'b0000_0011;
               short_blocks = 1'b1;
            end
            1: begin
               write_reg(alm_pkg::REG_MAX_SAMPLES, 1);
               write_reg(alm_pkg::REG_CLIP_LEVEL, 0);
               write_reg(alm_pkg::REG_HOLD_BLOCKS, 0);
               chan_mask    = '1;
               short_blocks = 1'b0;
            end
            2: begin
               write_reg(alm_pkg::REG_MAX_SAMPLES, 0);
               write_reg(alm_pkg::REG_CLIP_LEVEL, 511);
               write_reg(alm_pkg::REG_HOLD_BLOCKS, 1);
               chan_mask    = '1;
               short_blocks = 1'b0;
            end
            default: begin
               write_reg(alm_pkg::REG_MAX_SAMPLES,
                         ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                     : $urandom_range(2, 24));
               write_reg(alm_pkg::REG_CLIP_LEVEL,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(257, 511)
                                                     : $urandom_range(0, 256));
               write_reg(alm_pkg::REG_HOLD_BLOCKS, $urandom_range(0, 63));
               chan_mask    = alm_pkg::CHANNELS'($urandom);
               short_blocks = ($urandom_range(0, 3) == 0);
               if (chan_mask == '0) begin
                  chan_mask = '1;
               end
            end
         endcase
         csr_valid <= 1'b0;
         settings_used++;

         for (k = 0; k < PHASE_WORDS; k++) begin
            ch = alm_pkg::CHAN_W'($urandom_range(0, alm_pkg::CHANNELS - 1));
            while (!chan_mask[ch]) begin
               ch = alm_pkg::CHAN_W'($urandom_range(0, alm_pkg::CHANNELS - 1));
            end
            // plan the next block of this channel: mostly short, a few long
            // enough to reach or pass most sample limits
            if (block_left[ch] <= 0) begin
               block_src[ch] = sample_src_type'($urandom_range(0, 4));
               if (short_blocks) begin
                  block_left[ch] = $urandom_range(1, 3);
               end else if ($urandom_range(0, 99) < 80) begin
                  block_left[ch] = $urandom_range(1, 12);
               end else if ($urandom_range(0, 99) < 85) begin
                  block_left[ch] = $urandom_range(13, 40);
               end else begin
                  block_left[ch] = $urandom_range(200, 270);
               end
            end
            block_left[ch]--;
            // a stray block end now and then cuts a block short
            be = (block_left[ch] == 0) || ($urandom_range(0, 99) < 2);
            send_word(draw_sample(block_src[ch]), ch, be, 1'b0, none);
            if (be) begin
               block_left[ch] = 0;
            end
         end
      end

      drain();
      $display("covered %0d sample words and %0d level words under %0d register settings",
               words_sent, levels_checked, settings_used);
      $display("clip codes seen: none %0d, short %0d, long %0d",
               clip_seen[0], clip_seen[1], clip_seen[2]);
      if (fail_count == 0 && expected_levels.size() == 0) begin
         $display("audio_level_meter_peak_hold_core regression: pass");
      end else begin
         $display("audio_level_meter_peak_hold_core regression: fail");
      end
      $finish;
   end

endmodule

### audio_level_meter_peak_hold_core.f
src/alm_pkg.sv
src/alm_div.sv
src/alm_acc.sv
src/alm_peak.sv
src/audio_level_meter_peak_hold_core.sv
tb/tb_audio_level_meter_peak_hold_core.sv
